// File: hdl/kcl_pkg.sv
// shared types and constants of the keypad code lock
`default_nettype none
package kcl_pkg;

  localparam int unsigned CodeLength = 4;
  localparam int unsigned SymW       = 4;
  localparam int unsigned CntW       = $clog2(CodeLength);
  localparam int unsigned TickW      = 16;
  localparam int unsigned FailW      = 4;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [SymW-1:0]  SymStar         = 4'd14;
  localparam logic [SymW-1:0]  SymHash         = 4'd15;
  localparam logic [TickW-1:0] LockoutTicksRst = 16'd20000;
  localparam logic [FailW-1:0] FailLimitRst    = 4'd4;

  typedef enum logic [0:0] {
    CFG_LOCKOUT_TICKS = 1'b0,
    CFG_FAILURE_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_TAKEN    = 4'd1,
    EV_UNLOCK   = 4'd2,
    EV_WRONG    = 4'd3,
    EV_LOCKOUT  = 4'd4,
    EV_IGNORED  = 4'd5,
    EV_VERIFIED = 4'd6,
    EV_CHANGED  = 4'd7,
    EV_PHOTO    = 4'd8
  } event_e;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_VERIFY  = 2'd1,
    MODE_NEWCODE = 2'd2
  } mode_e;

  typedef struct packed {
    logic            req_type;
    logic [SymW-1:0] key_symbol;
  } kcl_in_t;

  typedef struct packed {
    logic [3:0] event_code;
    logic [1:0] lock_mode;
    logic [1:0] symbols_entered;
    logic       locked_out;
  } kcl_out_t;

  // control from the sequencing logic to the code store
  typedef struct packed {
    logic            wr_en;
    logic [CntW-1:0] wr_idx;
    logic [SymW-1:0] sym;
    logic            commit;
  } kcl_store_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/kcl_codes.sv
// entry buffer and stored code with the full-entry compare
`default_nettype none
module kcl_codes (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire kcl_pkg::kcl_store_ctrl_t ctrl_i,
  output logic                          match_o
);
  import kcl_pkg::*;

  logic [SymW-1:0] entry_q [CodeLength];
  logic [SymW-1:0] code_q  [CodeLength];
  logic [SymW-1:0] cand    [CodeLength];

  // candidate entry: buffer with the incoming symbol as its last entry
  always_comb begin
    for (int i = 0; i < CodeLength; i++) begin
      cand[i] = (i == CodeLength - 1) ? ctrl_i.sym : entry_q[i];
    end
  end

  always_comb begin
    match_o = 1'b1;
    for (int i = 0; i < CodeLength; i++) begin
      if (cand[i] != code_q[i]) begin
        match_o = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      entry_q[ctrl_i.wr_idx] <= ctrl_i.sym;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CodeLength; i++) begin
        code_q[i] <= '0;
      end
    end else if (ctrl_i.commit) begin
      for (int i = 0; i < CodeLength; i++) begin
        code_q[i] <= cand[i];
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/keypad_code_lock_controller.sv
// keypad code lock controller top level
// Usage: items arrive on the in channel (valid/ready); each is a key press
// (req_type 0, key_symbol 0-15) or one timer tick (req_type 1). Every item
// gives exactly one result on the out channel (valid/ready): event code,
// current mode, symbols held in the entry buffer and the lockout flag.
// The result of an item accepted at one edge is valid after that edge.
// Throughput is one item per cycle while the receiver takes each result,
// set by the single result register; the next item is taken while the
// result is taken in the same cycle.
// When the receiver stalls, the result register holds its item and in
// ready drops until that item is taken; no item is lost or repeated.
// The config port writes lockout_ticks (index 0) and failure_limit
// (index 1) on any edge with cfg_we_i high; write only while idle.
// Reset sets the code to four zero symbols, normal entry mode, zero
// failures, no lockout, lockout_ticks 20000 and failure_limit 4.
`default_nettype none
module keypad_code_lock_controller (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire kcl_pkg::kcl_in_t             in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output kcl_pkg::kcl_out_t                 out_data_o,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_addr_i,
  input  wire logic [kcl_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import kcl_pkg::*;

  logic [TickW-1:0] lock_ticks_q;
  logic [FailW-1:0] fail_limit_q;
  logic [TickW-1:0] lockout_q, lockout_d;
  logic [FailW-1:0] fail_cnt_q, fail_cnt_d;
  logic [FailW-1:0] fail_inc;
  logic [CntW-1:0]  cnt_q, cnt_d;
  mode_e            mode_q, mode_d;
  event_e           ev;
  logic             out_valid_q;
  kcl_out_t         out_q;
  logic             in_acc;
  logic             match;
  logic             is_key;
  kcl_store_ctrl_t  store_ctrl;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign fail_inc    = fail_cnt_q + 1'b1;
  assign is_key      = !in_data_i.req_type && (lockout_q == '0);

  kcl_codes u_codes (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (store_ctrl),
    .match_o (match)
  );

  always_comb begin
    lockout_d  = lockout_q;
    fail_cnt_d = fail_cnt_q;
    cnt_d      = cnt_q;
    mode_d     = mode_q;
    ev         = EV_NONE;
    store_ctrl.wr_en  = 1'b0;
    store_ctrl.wr_idx = cnt_q;
    store_ctrl.sym    = in_data_i.key_symbol;
    store_ctrl.commit = 1'b0;
    if (in_data_i.req_type) begin
      if (lockout_q != '0) begin
        lockout_d = lockout_q - 1'b1;
      end
    end else if (!is_key) begin
      ev = EV_IGNORED;
    end else if (in_data_i.key_symbol == SymStar || in_data_i.key_symbol == SymHash) begin
      cnt_d = '0;
      if (mode_q != MODE_NORMAL) begin
        ev = EV_IGNORED;
      end else if (in_data_i.key_symbol == SymHash) begin
        ev = EV_PHOTO;
      end else begin
        mode_d = MODE_VERIFY;
        ev     = EV_TAKEN;
      end
    end else if (cnt_q != CntW'(CodeLength - 1)) begin
      store_ctrl.wr_en = 1'b1;
      cnt_d = cnt_q + 1'b1;
      ev    = EV_TAKEN;
    end else begin
      // last symbol: compare or commit without storing it in the buffer
      cnt_d = '0;
      unique case (mode_q)
        MODE_NEWCODE: begin
          store_ctrl.commit = 1'b1;
          mode_d = MODE_NORMAL;
          ev     = EV_CHANGED;
        end
        default: begin
          if (match) begin
            fail_cnt_d = '0;
            if (mode_q == MODE_VERIFY) begin
              mode_d = MODE_NEWCODE;
              ev     = EV_VERIFIED;
            end else begin
              ev = EV_UNLOCK;
            end
          end else if (fail_inc >= fail_limit_q) begin
            fail_cnt_d = '0;
            lockout_d  = lock_ticks_q;
            ev         = EV_LOCKOUT;
          end else begin
            fail_cnt_d = fail_inc;
            ev         = EV_WRONG;
          end
        end
      endcase
    end
    if (!in_acc) begin
      store_ctrl.wr_en  = 1'b0;
      store_ctrl.commit = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_ticks_q <= LockoutTicksRst;
      fail_limit_q <= FailLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_LOCKOUT_TICKS: lock_ticks_q <= cfg_wdata_i[TickW-1:0];
        CFG_FAILURE_LIMIT: fail_limit_q <= cfg_wdata_i[FailW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q   <= '0;
      fail_cnt_q  <= '0;
      cnt_q       <= '0;
      mode_q      <= MODE_NORMAL;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        lockout_q   <= lockout_d;
        fail_cnt_q  <= fail_cnt_d;
        cnt_q       <= cnt_d;
        mode_q      <= mode_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q.event_code      <= ev;
      out_q.lock_mode       <= mode_d;
      out_q.symbols_entered <= 2'(cnt_d);
      out_q.locked_out      <= (lockout_d != '0);
    end
  end

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q) else $error("item accepted without a result");

  a_lockout_freezes_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_data_i.req_type && lockout_q != '0) |=>
      ($stable(mode_q) && $stable(cnt_q) && $stable(fail_cnt_q)))
    else $error("key changed state during lockout");

  a_tick_counts_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.req_type && lockout_q != '0) |=>
      (lockout_q == $past(lockout_q) - 1'b1))
    else $error("lockout did not count down on tick");

  a_flag_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (out_q.locked_out == (lockout_q != '0)))
    else $error("locked_out flag disagrees with lockout counter");

endmodule
`default_nettype wire
